[rtl/core/lfr_pkg.sv]
// Shared types and constants for the letter frequency rank unit.
`default_nettype none
package lfr_pkg;

  localparam int ALPHA_SIZE = 26;
  localparam int LETTER_W   = 5;
  localparam int COUNT_W    = 17;
  localparam int POS_W      = 16;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [POS_W-1:0]    pos_t;

  localparam letter_t LAST_IDX  = letter_t'(ALPHA_SIZE - 1);
  localparam letter_t ALPHA_LIM = letter_t'(ALPHA_SIZE);
  localparam count_t  MAX_COUNT = count_t'(65536);
  localparam pos_t    MAX_POS   = pos_t'(65535);

  // Ranking sequencer requests toward the tally memories.
  typedef struct packed {
    logic    scan;
    letter_t addr;
    logic    clear;
  } rank_ctrl_t;

  // Read data and occupancy flags returned by the tally.
  typedef struct packed {
    count_t                count;
    pos_t                  pos;
    logic [ALPHA_SIZE-1:0] seen;
  } tally_data_t;

endpackage
`default_nettype wire

[rtl/core/lfr_in_if.sv]
// Letter input channel.
`default_nettype none
interface lfr_in_if;
  logic                 valid;
  logic                 ready;
  lfr_pkg::letter_t     letter_code;
  logic                 last_letter;

  modport source (output valid, output letter_code, output last_letter, input ready);
  modport sink   (input valid, input letter_code, input last_letter, output ready);
endinterface
`default_nettype wire

[rtl/core/lfr_out_if.sv]
// Ranking result channel.
`default_nettype none
interface lfr_out_if;
  logic               valid;
  logic               ready;
  lfr_pkg::letter_t   letter_out;
  lfr_pkg::count_t    occurrences;
  logic               last_result;

  modport source (output valid, output letter_out, output occurrences, output last_result,
                  input ready);
  modport sink   (input valid, input letter_out, input occurrences, input last_result,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/lfr_tally.sv]
// Count and first-position memories with the per-letter read-modify-write.
`default_nettype none
module lfr_tally (
  input  wire                  clk,
  input  wire                  rst,
  lfr_in_if.sink               letters,
  input  lfr_pkg::rank_ctrl_t  ctrl,
  output lfr_pkg::tally_data_t data,
  output logic                 start
);

  lfr_pkg::count_t cnt_mem [lfr_pkg::ALPHA_SIZE];
  lfr_pkg::pos_t   pos_mem [lfr_pkg::ALPHA_SIZE];

  logic [lfr_pkg::ALPHA_SIZE-1:0] seen;
  logic                           hold;
  lfr_pkg::pos_t                  pos_ctr;

  logic             s1_valid;
  logic             s1_last;
  lfr_pkg::letter_t s1_code;

  logic             wr_valid;
  lfr_pkg::letter_t wr_code;
  lfr_pkg::count_t  wr_count;

  lfr_pkg::count_t  cnt_rd;
  lfr_pkg::pos_t    pos_rd;

  logic             accept;
  logic             in_range;
  lfr_pkg::letter_t rd_addr;
  logic             rd_en;
  lfr_pkg::count_t  prior;
  lfr_pkg::count_t  old_count;
  lfr_pkg::count_t  new_count;
  logic             first_seen;

  assign letters.ready = !hold;
  assign accept   = letters.valid && letters.ready;
  assign in_range = letters.letter_code < lfr_pkg::ALPHA_LIM;
  assign rd_addr  = ctrl.scan ? ctrl.addr : letters.letter_code;
  assign rd_en    = ctrl.scan || (accept && in_range);

  // Forward the count written last cycle: the memory read missed it.
  assign prior      = (wr_valid && wr_code == s1_code) ? wr_count : cnt_rd;
  assign first_seen = !seen[s1_code];
  assign old_count  = first_seen ? '0 : prior;
  assign new_count  = (old_count == lfr_pkg::MAX_COUNT) ? old_count
                                                        : old_count + lfr_pkg::count_t'(1);

  assign start = s1_last;
  assign data  = '{count: cnt_rd, pos: pos_rd, seen: seen};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cnt_rd <= cnt_mem[rd_addr];
      pos_rd <= pos_mem[rd_addr];
    end
    if (s1_valid) begin
      cnt_mem[s1_code] <= new_count;
      if (first_seen) begin
        pos_mem[s1_code] <= pos_ctr;
      end
    end
    wr_code  <= s1_code;
    wr_count <= new_count;
    s1_code  <= letters.letter_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      hold     <= 1'b0;
      pos_ctr  <= '0;
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      s1_valid <= accept && in_range;
      s1_last  <= accept && letters.last_letter;
      wr_valid <= s1_valid;
      if (accept && letters.last_letter) begin
        hold <= 1'b1;
      end
      if (s1_valid) begin
        seen[s1_code] <= 1'b1;
        if (pos_ctr != lfr_pkg::MAX_POS) begin
          pos_ctr <= pos_ctr + lfr_pkg::pos_t'(1);
        end
      end
      if (ctrl.clear) begin
        seen    <= '0;
        pos_ctr <= '0;
        hold    <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/lfr_rank.sv]
// Ranking sequencer: repeated selection scans over the tally memories.
`default_nettype none
module lfr_rank (
  input  wire                  clk,
  input  wire                  rst,
  input  logic                 start,
  input  lfr_pkg::tally_data_t data,
  output lfr_pkg::rank_ctrl_t  ctrl,
  lfr_out_if.source            ranking
);

  typedef enum logic [1:0] {IDLE, SCAN, DECIDE} state_t;

  state_t                         state;
  logic                           iss;
  lfr_pkg::letter_t               idx;
  logic                           chk_valid;
  lfr_pkg::letter_t               chk_idx;
  logic [lfr_pkg::ALPHA_SIZE-1:0] emitted;
  logic                           best_valid;
  lfr_pkg::letter_t               best_code;
  lfr_pkg::count_t                best_count;
  lfr_pkg::pos_t                  best_pos;
  logic [1:0]                     cand;

  logic             out_valid;
  lfr_pkg::letter_t out_letter;
  lfr_pkg::count_t  out_count;
  logic             out_last;

  logic candidate;
  logic ahead;
  logic out_free;
  logic load;
  logic clear;

  assign candidate = chk_valid && data.seen[chk_idx] && !emitted[chk_idx];
  // Strict compares keep the lower index on a full tie, since the scan ascends.
  assign ahead = !best_valid || (data.count > best_count) ||
                 (data.count == best_count && data.pos < best_pos);
  assign out_free = !out_valid || ranking.ready;
  assign load     = (state == DECIDE) && best_valid && out_free;
  assign clear    = (state == DECIDE) && (!best_valid || (out_free && cand == 2'd1));

  assign ctrl = '{scan: (state == SCAN) && iss, addr: idx, clear: clear};

  assign ranking.valid       = out_valid;
  assign ranking.letter_out  = out_letter;
  assign ranking.occurrences = out_count;
  assign ranking.last_result = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      iss        <= 1'b0;
      idx        <= '0;
      chk_valid  <= 1'b0;
      chk_idx    <= '0;
      emitted    <= '0;
      best_valid <= 1'b0;
      cand       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ranking.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            state      <= SCAN;
            iss        <= 1'b1;
            idx        <= '0;
            chk_valid  <= 1'b0;
            best_valid <= 1'b0;
            cand       <= '0;
          end
        end
        SCAN: begin
          chk_valid <= iss;
          chk_idx   <= idx;
          if (iss) begin
            if (idx == lfr_pkg::LAST_IDX) begin
              iss <= 1'b0;
            end else begin
              idx <= idx + lfr_pkg::letter_t'(1);
            end
          end
          if (candidate) begin
            if (cand != 2'd2) begin
              cand <= cand + 2'd1;
            end
            if (ahead) begin
              best_valid <= 1'b1;
              best_code  <= chk_idx;
              best_count <= data.count;
              best_pos   <= data.pos;
            end
          end
          if (chk_valid && chk_idx == lfr_pkg::LAST_IDX) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          if (load) begin
            out_valid          <= 1'b1;
            out_letter         <= best_code;
            out_count          <= best_count;
            out_last           <= (cand == 2'd1);
            emitted[best_code] <= 1'b1;
            // Rescan for the next pick.
            state      <= SCAN;
            iss        <= 1'b1;
            idx        <= '0;
            chk_valid  <= 1'b0;
            best_valid <= 1'b0;
            cand       <= '0;
          end
          if (clear) begin
            state   <= IDLE;
            iss     <= 1'b0;
            emitted <= '0;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/letter_frequency_rank_unit.sv]
// Top level of the letter frequency rank unit.
// Letters are taken one per cycle: each is a single read-modify-write of the count
// memory, with the previous write forwarded when the same letter repeats. The transfer
// of a letter flagged last closes the string; input stays stalled while the ranking
// runs. Ranking is a selection scan that reads every entry of the count and position
// memories through their single read port for each ranked letter, and each result also
// waits for the result register to drain; a string with no counted letter ends after
// one scan and gives no result. Memories need no clearing pass: per-letter seen flags
// are cleared at reset and after each ranking.
`default_nettype none
module letter_frequency_rank_unit (
  input  wire       clk,
  input  wire       rst,
  lfr_in_if.sink    letters,
  lfr_out_if.source ranking
);

  lfr_pkg::rank_ctrl_t  ctrl;
  lfr_pkg::tally_data_t data;
  logic                 start;

  lfr_tally u_tally (
    .clk     (clk),
    .rst     (rst),
    .letters (letters),
    .ctrl    (ctrl),
    .data    (data),
    .start   (start)
  );

  lfr_rank u_rank (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .data    (data),
    .ctrl    (ctrl),
    .ranking (ranking)
  );

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    letters.valid && letters.ready && letters.last_letter |=> !letters.ready)
    else $error("input not stalled after last letter");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    ctrl.scan |-> !letters.ready)
    else $error("letter accepted during ranking scan");

  a_nonzero_count: assert property (@(posedge clk) disable iff (rst)
    ranking.valid |-> ranking.occurrences != '0)
    else $error("ranked letter with zero count");

endmodule
`default_nettype wire

[tb/sv/letter_rank_checker.sv]
// Checker for the letter frequency rank unit: predicts each ranking and compares results.
module letter_rank_checker
  import lfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lfr_in_if    letters,
  lfr_out_if   ranking,
  output int   fail_count,
  output int   pending_results,
  output int   strings_closed,
  output int   results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    letter_t letter;
    count_t  count;
    logic    tail;
  } rank_entry_t;

  count_t      tally [ALPHA_SIZE];
  pos_t        first_at [ALPHA_SIZE];
  pos_t        position;
  rank_entry_t ranks_due [$];
  int          errors = 0;

  assign fail_count = errors;

  task automatic report(input string what);
    $display("[%0t] ranking mismatch: %s", $time, what);
    errors++;
  endtask

  // Select by count, then by first position; the ascending scan keeps the lower letter on a
  // full tie.
  task automatic rank_tally();
    logic [ALPHA_SIZE-1:0] taken;
    int                    best;
    int                    total;
    int                    made;
    rank_entry_t           entry;
    taken = '0;
    total = 0;
    made  = 0;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (tally[i] != '0) total++;
    end
    while (made < total) begin
      best = -1;
      for (int i = 0; i < ALPHA_SIZE; i++) begin
        if (tally[i] != '0 && !taken[i]) begin
          if (best < 0) begin
            best = i;
          end else if (tally[i] > tally[best] ||
                       (tally[i] == tally[best] && first_at[i] < first_at[best])) begin
            best = i;
          end
        end
      end
      taken[best] = 1'b1;
      made++;
      entry.letter = letter_t'(best);
      entry.count  = tally[best];
      entry.tail   = (made == total);
      ranks_due.push_back(entry);
    end
  endtask

  task automatic clear_tally();
    for (int i = 0; i < ALPHA_SIZE; i++) tally[i] = '0;
    position = '0;
  endtask

  always @(posedge clk) begin
    rank_entry_t want;
    if (rst) begin
      clear_tally();
      ranks_due.delete();
      pending_results <= 0;
      strings_closed  <= 0;
      results_checked <= 0;
    end else begin
      if (letters.valid && letters.ready) begin
        // Out-of-range codes are dropped but may still close the string.
        if (letters.letter_code < ALPHA_LIM) begin
          if (tally[letters.letter_code] == '0) first_at[letters.letter_code] = position;
          if (tally[letters.letter_code] < MAX_COUNT) begin
            tally[letters.letter_code] = tally[letters.letter_code] + 1'b1;
          end
          if (position < MAX_POS) position = position + 1'b1;
        end
        if (letters.last_letter) begin
          rank_tally();
          clear_tally();
          strings_closed <= strings_closed + 1;
        end
      end
      if (ranking.valid && ranking.ready) begin
        if (ranks_due.size() == 0) begin
          report($sformatf("unexpected result letter %0d count %0d last %0b",
                           ranking.letter_out, ranking.occurrences, ranking.last_result));
        end else begin
          want = ranks_due.pop_front();
          if (ranking.letter_out !== want.letter) begin
            report($sformatf("letter %0d, want %0d", ranking.letter_out, want.letter));
          end
          if (ranking.occurrences !== want.count) begin
            report($sformatf("letter %0d count %0d, want %0d",
                             want.letter, ranking.occurrences, want.count));
          end
          if (ranking.last_result !== want.tail) begin
            report($sformatf("letter %0d last flag %0b, want %0b",
                             want.letter, ranking.last_result, want.tail));
          end
        end
        results_checked <= results_checked + 1;
      end
      pending_results <= ranks_due.size();
    end
  end

endmodule

[tb/sv/tb_letter_frequency_rank_unit.sv]
// Testbench top for the letter frequency rank unit: stimulus, handshake pacing and verdict.
module tb_letter_frequency_rank_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lfr_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = 1000;
  localparam int GAP_MAX      = 6;

  localparam letter_t LTR_A    = letter_t'(0);
  localparam letter_t LTR_B    = letter_t'(1);
  localparam letter_t LTR_C    = letter_t'(2);
  localparam letter_t LTR_D    = letter_t'(3);
  localparam letter_t LTR_E    = letter_t'(4);
  localparam letter_t LTR_F    = letter_t'(5);
  localparam letter_t LTR_Z    = LAST_IDX;
  localparam letter_t CODE_TOP = letter_t'(31);

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles       = 0;
  int   letters_sent = 0;
  int   src_gap_max  = GAP_MAX;
  int   sink_gap_max = GAP_MAX;
  int   fail_count;
  int   pending_results;
  int   strings_closed;
  int   results_checked;

  lfr_in_if  letters ();
  lfr_out_if ranking ();

  letter_frequency_rank_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .letters (letters),
    .ranking (ranking)
  );

  letter_rank_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .letters         (letters),
    .ranking         (ranking),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .strings_closed  (strings_closed),
    .results_checked (results_checked)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
      $display("letter_frequency_rank_unit regression: fail");
      $finish;
    end
  end

  // Hold valid low for a random gap, then present the letter until its transfer.
  task automatic send_letter(input letter_t code, input logic last);
    int gap;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(src_gap_max, 0);
    if (gap > 0) begin
      letters.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    letters.valid       <= 1'b1;
    letters.letter_code <= code;
    letters.last_letter <= last;
    @(posedge clk);
    while (!letters.ready) @(posedge clk);
    letters_sent++;
  endtask

  function automatic int pick_gap_max();
    return ($urandom_range(3, 0) == 0) ? 0 : GAP_MAX;
  endfunction

  // Narrow pools give many count ties; noise strings may hold no countable letter.
  function automatic letter_t draw_code(input bit noisy, input letter_t base, input int pool);
    if (noisy) return letter_t'($urandom_range(31, 0));
    if ($urandom_range(15, 0) == 0) return letter_t'($urandom_range(31, ALPHA_SIZE));
    return letter_t'((base + $urandom_range(pool - 1, 0)) % ALPHA_SIZE);
  endfunction

  task automatic send_random_string();
    int      kind;
    int      len;
    int      pool;
    int      j;
    letter_t base;
    letter_t tmp;
    letter_t perm [ALPHA_SIZE];
    kind         = $urandom_range(9, 0);
    src_gap_max  = pick_gap_max();
    sink_gap_max = pick_gap_max();
    base         = letter_t'($urandom_range(ALPHA_SIZE - 1, 0));
    if (kind == 7) begin
      // Full alphabet in shuffled order, then a few repeats.
      for (int i = 0; i < ALPHA_SIZE; i++) perm[i] = letter_t'(i);
      for (int i = ALPHA_SIZE - 1; i > 0; i--) begin
        j       = $urandom_range(i, 0);
        tmp     = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      len = $urandom_range(GAP_MAX, 0);
      for (int i = 0; i < ALPHA_SIZE; i++) send_letter(perm[i], i == ALPHA_SIZE - 1 && len == 0);
      for (int n = 0; n < len; n++) send_letter(draw_code(1'b0, LTR_A, ALPHA_SIZE), n == len - 1);
    end else begin
      if (kind < 5) begin
        pool = $urandom_range(4, 1);
        len  = $urandom_range(12, 1);
      end else if (kind < 7) begin
        pool = ALPHA_SIZE;
        base = LTR_A;
        len  = $urandom_range(40, 1);
      end else begin
        pool = ALPHA_SIZE;
        len  = $urandom_range(6, 1);
      end
      for (int n = 0; n < len; n++) send_letter(draw_code(kind >= 8, base, pool), n == len - 1);
    end
  endtask

  initial begin
    int stall;
    ranking.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (sink_gap_max == 0) ? 0 : $urandom_range(sink_gap_max, 0);
      if (stall > 0) begin
        ranking.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      ranking.ready <= 1'b1;
      @(posedge clk);
      while (!ranking.valid) @(posedge clk);
    end
  end

  initial begin
    int random_start;
    letters.valid       <= 1'b0;
    letters.letter_code <= '0;
    letters.last_letter <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_letter(LTR_A, 1'b1);
    send_letter(LTR_Z, 1'b0);
    send_letter(LTR_Z, 1'b1);
    // Strings with nothing counted give no result.
    send_letter(CODE_TOP, 1'b1);
    send_letter(ALPHA_LIM, 1'b1);
    // Equal counts split by first position; the dropped code does not advance the position.
    send_letter(LTR_B, 1'b0);
    send_letter(LTR_A, 1'b0);
    send_letter(LTR_B, 1'b0);
    send_letter(LTR_C, 1'b0);
    send_letter(LTR_A, 1'b0);
    send_letter(ALPHA_LIM + 1'b1, 1'b0);
    send_letter(LTR_D, 1'b1);
    // A dropped code still closes the string.
    send_letter(LTR_E, 1'b0);
    send_letter(LTR_F, 1'b0);
    send_letter(CODE_TOP, 1'b1);

    random_start = letters_sent;
    while (letters_sent - random_start < RANDOM_ITEMS) send_random_string();

    letters.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d letters in %0d strings, checked %0d ranked results",
             letters_sent, strings_closed, results_checked);
    $display("covered field extremes, dropped codes, empty strings, ties, full alphabets");
    if (fail_count == 0) begin
      $display("letter_frequency_rank_unit regression: pass");
    end else begin
      $display("letter_frequency_rank_unit regression: fail");
    end
    $finish;
  end

endmodule
